>>> src/sgf_pkg.sv
// shared types, codes and fixed-point helpers for the space group 67 structure factor block
package sgf_pkg;

	localparam int SUM_W  = 32;
	localparam int COS_W  = 16;
	localparam int TERM_W = 22;
	localparam int PROD_W = 48;
	localparam int CFG_W  = 16;
	localparam int CIDX_W = 2;

	localparam logic [CIDX_W-1:0] REG_SETTING = 2'd0;
	localparam logic [CIDX_W-1:0] REG_ATOM_X  = 2'd1;
	localparam logic [CIDX_W-1:0] REG_ATOM_Y  = 2'd2;
	localparam logic [CIDX_W-1:0] REG_ATOM_Z  = 2'd3;

	localparam logic [2:0] SET_STANDARD = 3'd0;
	localparam logic [2:0] SET_BA_C     = 3'd1;
	localparam logic [2:0] SET_CAB      = 3'd2;
	localparam logic [2:0] SET_MCBA     = 3'd3;
	localparam logic [2:0] SET_BCA      = 3'd4;
	localparam logic [2:0] SET_A_CB     = 3'd5;

	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

	localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;
	localparam logic [63:0] ONE_Q62     = 64'h4000000000000000;

	typedef struct packed {
		logic       ok;
		logic [1:0] a;
		logic [1:0] b;
		logic [1:0] c;
		logic [1:0] p;
	} plan_t;

	typedef struct packed {
		logic en_s2;
		logic en_s3;
	} lane_ctl_t;

	typedef struct packed {
		logic en_s4;
		logic en_s5;
		logic en_s6;
	} term_ctl_t;

	// axis roles per setting: a, b (+a/4), c (-a/4), parity partner of a
	function automatic plan_t axis_plan(input logic [2:0] setting);
		plan_t pl;
		pl = '{ok: 1'b0, a: AXIS_X, b: AXIS_Y, c: AXIS_Z, p: AXIS_Y};
		case (setting)
			SET_STANDARD: pl = '{ok: 1'b1, a: AXIS_X, b: AXIS_Y, c: AXIS_Z, p: AXIS_Y};
			SET_BA_C:     pl = '{ok: 1'b1, a: AXIS_Y, b: AXIS_X, c: AXIS_Z, p: AXIS_X};
			SET_CAB:      pl = '{ok: 1'b1, a: AXIS_Y, b: AXIS_Z, c: AXIS_X, p: AXIS_Z};
			SET_MCBA:     pl = '{ok: 1'b1, a: AXIS_Z, b: AXIS_X, c: AXIS_Y, p: AXIS_Y};
			SET_BCA:      pl = '{ok: 1'b1, a: AXIS_Z, b: AXIS_X, c: AXIS_Y, p: AXIS_X};
			SET_A_CB:     pl = '{ok: 1'b1, a: AXIS_X, b: AXIS_Z, c: AXIS_Y, p: AXIS_Z};
			default:      pl.ok = 1'b0;
		endcase
		return pl;
	endfunction

	// q62 fixed-point multiply, elaboration use only
	function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] full;
		full = 128'(a) * 128'(b);
		return full[125:62];
	endfunction

endpackage

>>> src/sgf_phase.sv
// axis routing and phase computation in turns, first pipeline stage
module sgf_phase #(
	parameter int INDEX_BITS = 8,
	parameter int COORD_BITS = 16
) (
	input  logic                         clk,
	input  logic                         en_s1,
	input  logic [2:0]                   setting,
	input  logic [INDEX_BITS-1:0]        ix_h,
	input  logic [INDEX_BITS-1:0]        ix_k,
	input  logic [INDEX_BITS-1:0]        ix_l,
	input  logic [COORD_BITS-1:0]        crd_x,
	input  logic [COORD_BITS-1:0]        crd_y,
	input  logic [COORD_BITS-1:0]        crd_z,
	output logic [COORD_BITS-1:0]        phase_a_s1,
	output logic [COORD_BITS-1:0]        phase_b_s1,
	output logic [COORD_BITS-1:0]        phase_c_s1,
	output logic                         live_s1
);

	localparam int PW = INDEX_BITS + COORD_BITS + 1;

	sgf_pkg::plan_t              pl;
	logic [INDEX_BITS-1:0]       ia, ib, ic, ip;
	logic [COORD_BITS-1:0]       ca, cb, cc;
	logic signed [PW-1:0]        pa, pb, pc;
	logic [COORD_BITS-1:0]       quarter;

	function automatic logic [INDEX_BITS-1:0] pick_ix(input logic [1:0] ax,
		input logic [INDEX_BITS-1:0] h, input logic [INDEX_BITS-1:0] k,
		input logic [INDEX_BITS-1:0] l);
		logic [INDEX_BITS-1:0] r;
		case (ax)
			sgf_pkg::AXIS_X: r = h;
			sgf_pkg::AXIS_Y: r = k;
			default:         r = l;
		endcase
		return r;
	endfunction

	function automatic logic [COORD_BITS-1:0] pick_crd(input logic [1:0] ax,
		input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y,
		input logic [COORD_BITS-1:0] z);
		logic [COORD_BITS-1:0] r;
		case (ax)
			sgf_pkg::AXIS_X: r = x;
			sgf_pkg::AXIS_Y: r = y;
			default:         r = z;
		endcase
		return r;
	endfunction

	always_comb begin
		pl = sgf_pkg::axis_plan(setting);
		ia = pick_ix(pl.a, ix_h, ix_k, ix_l);
		ib = pick_ix(pl.b, ix_h, ix_k, ix_l);
		ic = pick_ix(pl.c, ix_h, ix_k, ix_l);
		ip = pick_ix(pl.p, ix_h, ix_k, ix_l);
		ca = pick_crd(pl.a, crd_x, crd_y, crd_z);
		cb = pick_crd(pl.b, crd_x, crd_y, crd_z);
		cc = pick_crd(pl.c, crd_x, crd_y, crd_z);
		pa = PW'($signed(ia) * $signed({1'b0, ca}));
		pb = PW'($signed(ib) * $signed({1'b0, cb}));
		pc = PW'($signed(ic) * $signed({1'b0, cc}));
		// index times a quarter turn keeps only its two low bits
		quarter = {ia[1:0], {(COORD_BITS-2){1'b0}}};
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			phase_a_s1 <= pa[COORD_BITS-1:0];
			phase_b_s1 <= pb[COORD_BITS-1:0] + quarter;
			phase_c_s1 <= pc[COORD_BITS-1:0] - quarter;
			live_s1    <= pl.ok && !(ia[0] ^ ip[0]);
		end
	end

endmodule

>>> src/sgf_cos_lane.sv
// one cosine lane: table index stage and registered cosine table read
module sgf_cos_lane #(
	parameter int COORD_BITS      = 16,
	parameter int COS_TABLE_DEPTH = 1024
) (
	input  logic                             clk,
	input  sgf_pkg::lane_ctl_t               ctl,
	input  logic [COORD_BITS-1:0]            phase_s1,
	output logic signed [sgf_pkg::COS_W-1:0] cos_s3
);

	localparam int IDX_W = $clog2(COS_TABLE_DEPTH);
	localparam int MW    = COORD_BITS + IDX_W;

	// taylor series step divisor (2n-1)*2n
	function automatic logic [63:0] taylor_div(input logic [63:0] v, input int n);
		case (n)
			1:       return v / 64'd2;
			2:       return v / 64'd12;
			3:       return v / 64'd30;
			4:       return v / 64'd56;
			5:       return v / 64'd90;
			6:       return v / 64'd132;
			7:       return v / 64'd182;
			8:       return v / 64'd240;
			9:       return v / 64'd306;
			10:      return v / 64'd380;
			11:      return v / 64'd462;
			12:      return v / 64'd552;
			13:      return v / 64'd650;
			14:      return v / 64'd756;
			15:      return v / 64'd870;
			default: return v / 64'd992;
		endcase
	endfunction

	function automatic logic [15:0] cos_quarter(input logic [63:0] num);
		logic [63:0]        t, t2, term, r;
		logic signed [63:0] acc;
		t = (sgf_pkg::HALF_PI_Q62 / COS_TABLE_DEPTH) * num
			+ ((sgf_pkg::HALF_PI_Q62 % COS_TABLE_DEPTH) * num) / COS_TABLE_DEPTH;
		t2 = sgf_pkg::mul_q62(t, t);
		term = sgf_pkg::ONE_Q62;
		acc = $signed(sgf_pkg::ONE_Q62);
		for (int n = 1; n <= 16; n++) begin
			term = taylor_div(sgf_pkg::mul_q62(term, t2), n);
			if ((n % 2) == 1)
				acc = acc - $signed(term);
			else
				acc = acc + $signed(term);
		end
		if (acc < 0)
			acc = 64'sd0;
		r = ($unsigned(acc) + (64'd1 << 46)) >> 47;
		if (r > 64'd32767)
			r = 64'd32767;
		return r[15:0];
	endfunction

	function automatic logic signed [15:0] cos_entry(input int i);
		logic [63:0] n4, q, rem, d;
		logic [15:0] v;
		d = 64'(COS_TABLE_DEPTH);
		n4 = 64'(4 * i);
		q = n4 / COS_TABLE_DEPTH;
		rem = n4 % COS_TABLE_DEPTH;
		case (q)
			64'd0:   v = cos_quarter(rem);
			64'd1:   v = -cos_quarter(d - rem);
			64'd2:   v = -cos_quarter(rem);
			default: v = cos_quarter(d - rem);
		endcase
		return $signed(v);
	endfunction

	logic signed [sgf_pkg::COS_W-1:0] rom [COS_TABLE_DEPTH];
	logic [MW-1:0]                    scaled;
	logic [IDX_W-1:0]                 idx_s2;

	for (genvar g = 0; g < COS_TABLE_DEPTH; g++) begin : g_rom
		localparam logic signed [sgf_pkg::COS_W-1:0] ENTRY = cos_entry(g);
		assign rom[g] = ENTRY;
	end

	assign scaled = MW'(phase_s1) * MW'(COS_TABLE_DEPTH);

	always_ff @(posedge clk) begin
		if (ctl.en_s2)
			idx_s2 <= scaled[MW-1:COORD_BITS];
		if (ctl.en_s3)
			cos_s3 <= rom[idx_s2];
	end

endmodule

>>> src/sgf_term.sv
// triple cosine product and rounding to a q2.20 term
module sgf_term (
	input  logic                              clk,
	input  sgf_pkg::term_ctl_t                ctl,
	input  logic signed [sgf_pkg::COS_W-1:0]  cos_a_s3,
	input  logic signed [sgf_pkg::COS_W-1:0]  cos_b_s3,
	input  logic signed [sgf_pkg::COS_W-1:0]  cos_c_s3,
	input  logic                              live_s5,
	output logic signed [sgf_pkg::TERM_W-1:0] term_s6
);

	localparam int PW = sgf_pkg::PROD_W;

	logic signed [2*sgf_pkg::COS_W-1:0] p12_s4;
	logic signed [sgf_pkg::COS_W-1:0]   c3_s4;
	logic signed [PW-1:0]               p_s5;
	logic [PW-1:0]                      mag;
	logic [PW-1:0]                      rnd;
	logic signed [sgf_pkg::TERM_W-1:0]  rmag;

	always_comb begin
		mag  = p_s5[PW-1] ? PW'(-p_s5) : PW'(p_s5);
		rnd  = (mag + (PW'(1) << 24)) >> 25;
		rmag = $signed(rnd[sgf_pkg::TERM_W-1:0]);
	end

	always_ff @(posedge clk) begin
		if (ctl.en_s4) begin
			p12_s4 <= cos_a_s3 * cos_b_s3;
			c3_s4  <= cos_c_s3;
		end
		if (ctl.en_s5)
			p_s5 <= p12_s4 * c3_s4;
		if (ctl.en_s6) begin
			if (!live_s5)
				term_s6 <= '0;
			else if (p_s5[PW-1])
				term_s6 <= -rmag;
			else
				term_s6 <= rmag;
		end
	end

endmodule

>>> src/geometric_structure_factor_sg67.sv
// top level: space group 67 geometric structure factor accumulate step
//
// One input item carries a reflection (h, k, l) and a running sum; the atom position
// and the axis setting come from the configuration channel (index 0 setting, 1..3
// x, y, z). Each item yields one result: the sum plus this atom's term, saturated to
// the signed 32-bit range, with a flag when clipping happened.
// The datapath is a seven stage pipeline: phase products, table index, cosine table
// read (three lanes), two multiplies, rounding, saturating add into the output
// register. One item per cycle is taken in steady state while m_tready stays high.
// Each stage advances when it is empty or the next stage advances, so a stalled
// receiver holds the result in the output register while bubbles ahead of it are
// still filled; s_tready falls only when every stage holds an item.
// Reset empties the pipeline and clears the setting and atom coordinates to zero.
// Configuration is taken every cycle (cfg_ready is high) and must only be written
// while no item is in flight.
module geometric_structure_factor_sg67 #(
	parameter int COORD_BITS      = 16,
	parameter int INDEX_BITS      = 8,
	parameter int COS_TABLE_DEPTH = 1024
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [55:0]                        s_tdata,   // index_h, index_k, index_l, sum_in
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [39:0]                        m_tdata,   // sum_out, saturated, zero pad
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [sgf_pkg::CIDX_W-1:0]         cfg_index,
	input  logic [sgf_pkg::CFG_W-1:0]          cfg_data
);

	localparam int NST = 7;

	logic [2:0]                        setting_q;
	logic [COORD_BITS-1:0]             atom_x_q, atom_y_q, atom_z_q;
	logic [NST:1]                      vld_q;
	logic [NST+1:1]                    adv;

	logic [COORD_BITS-1:0]             phase_a_s1, phase_b_s1, phase_c_s1;
	logic                              live_s1, live_s2, live_s3, live_s4, live_s5;
	logic signed [sgf_pkg::SUM_W-1:0]  sum_s1, sum_s2, sum_s3, sum_s4, sum_s5, sum_s6;
	logic signed [sgf_pkg::COS_W-1:0]  cos_a_s3, cos_b_s3, cos_c_s3;
	logic signed [sgf_pkg::TERM_W-1:0] term_s6;
	logic signed [sgf_pkg::SUM_W:0]    total;
	logic signed [sgf_pkg::SUM_W-1:0]  sum_out_s7;
	logic                              sat_s7;
	sgf_pkg::lane_ctl_t                lane_ctl;
	sgf_pkg::term_ctl_t                term_ctl;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setting_q <= '0;
			atom_x_q  <= '0;
			atom_y_q  <= '0;
			atom_z_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				sgf_pkg::REG_SETTING: setting_q <= cfg_data[2:0];
				sgf_pkg::REG_ATOM_X:  atom_x_q  <= COORD_BITS'(cfg_data);
				sgf_pkg::REG_ATOM_Y:  atom_y_q  <= COORD_BITS'(cfg_data);
				sgf_pkg::REG_ATOM_Z:  atom_z_q  <= COORD_BITS'(cfg_data);
				default: ;
			endcase
		end
	end

	// stage advance chain from the output back to the input
	always_comb begin
		adv[NST+1] = m_tready;
		for (int i = NST; i >= 1; i--)
			adv[i] = !vld_q[i] || adv[i+1];
	end

	assign s_tready = adv[1];
	assign m_tvalid = vld_q[NST];
	assign lane_ctl = '{en_s2: adv[2], en_s3: adv[3]};
	assign term_ctl = '{en_s4: adv[4], en_s5: adv[5], en_s6: adv[6]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[1])
				vld_q[1] <= s_tvalid;
			for (int i = 2; i <= NST; i++)
				if (adv[i])
					vld_q[i] <= vld_q[i-1];
		end
	end

	sgf_phase #(
		.INDEX_BITS (INDEX_BITS),
		.COORD_BITS (COORD_BITS)
	) u_phase (
		.clk        (clk),
		.en_s1      (adv[1]),
		.setting    (setting_q),
		.ix_h       (INDEX_BITS'(s_tdata[7:0])),
		.ix_k       (INDEX_BITS'(s_tdata[15:8])),
		.ix_l       (INDEX_BITS'(s_tdata[23:16])),
		.crd_x      (atom_x_q),
		.crd_y      (atom_y_q),
		.crd_z      (atom_z_q),
		.phase_a_s1 (phase_a_s1),
		.phase_b_s1 (phase_b_s1),
		.phase_c_s1 (phase_c_s1),
		.live_s1    (live_s1)
	);

	sgf_cos_lane #(.COORD_BITS(COORD_BITS), .COS_TABLE_DEPTH(COS_TABLE_DEPTH)) u_lane_a (
		.clk      (clk),
		.ctl      (lane_ctl),
		.phase_s1 (phase_a_s1),
		.cos_s3   (cos_a_s3)
	);

	sgf_cos_lane #(.COORD_BITS(COORD_BITS), .COS_TABLE_DEPTH(COS_TABLE_DEPTH)) u_lane_b (
		.clk      (clk),
		.ctl      (lane_ctl),
		.phase_s1 (phase_b_s1),
		.cos_s3   (cos_b_s3)
	);

	sgf_cos_lane #(.COORD_BITS(COORD_BITS), .COS_TABLE_DEPTH(COS_TABLE_DEPTH)) u_lane_c (
		.clk      (clk),
		.ctl      (lane_ctl),
		.phase_s1 (phase_c_s1),
		.cos_s3   (cos_c_s3)
	);

	sgf_term u_term (
		.clk      (clk),
		.ctl      (term_ctl),
		.cos_a_s3 (cos_a_s3),
		.cos_b_s3 (cos_b_s3),
		.cos_c_s3 (cos_c_s3),
		.live_s5  (live_s5),
		.term_s6  (term_s6)
	);

	// sum and term-enable ride alongside the datapath
	always_ff @(posedge clk) begin
		if (adv[1])
			sum_s1 <= $signed(s_tdata[55:24]);
		if (adv[2]) begin
			sum_s2  <= sum_s1;
			live_s2 <= live_s1;
		end
		if (adv[3]) begin
			sum_s3  <= sum_s2;
			live_s3 <= live_s2;
		end
		if (adv[4]) begin
			sum_s4  <= sum_s3;
			live_s4 <= live_s3;
		end
		if (adv[5]) begin
			sum_s5  <= sum_s4;
			live_s5 <= live_s4;
		end
		if (adv[6])
			sum_s6 <= sum_s5;
		if (adv[7]) begin
			if (total[sgf_pkg::SUM_W] != total[sgf_pkg::SUM_W-1]) begin
				sum_out_s7 <= total[sgf_pkg::SUM_W] ? {1'b1, {(sgf_pkg::SUM_W-1){1'b0}}}
					: {1'b0, {(sgf_pkg::SUM_W-1){1'b1}}};
				sat_s7 <= 1'b1;
			end else begin
				sum_out_s7 <= total[sgf_pkg::SUM_W-1:0];
				sat_s7     <= 1'b0;
			end
		end
	end

	assign total   = (sgf_pkg::SUM_W+1)'(sum_s6) + (sgf_pkg::SUM_W+1)'(term_s6);
	assign m_tdata = {7'd0, sat_s7, sum_out_s7};

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && !m_tready && vld_q[1]))
		else $error("input stalled while the pipeline has room");

	a_sat_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && sat_s7) |->
		(sum_out_s7 == {1'b1, {(sgf_pkg::SUM_W-1){1'b0}}} ||
		 sum_out_s7 == {1'b0, {(sgf_pkg::SUM_W-1){1'b1}}}))
		else $error("saturated result not at a signed limit");

	a_dead_term_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q[5] && adv[6] && !live_s5) |=> (term_s6 == '0))
		else $error("term not zero for odd parity or unused setting");

	a_out_from_stage: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q[6] && adv[7]) |=> m_tvalid)
		else $error("item lost between last two stages");

endmodule

>>> verif/testbench.sv
// self-checking testbench for the space group 67 structure factor accumulate block
`timescale 1ns / 100ps

module testbench;

	localparam int STALL_LIMIT = 2000;
	localparam int PIPE_PAUSE  = 12;

	typedef struct packed {
		logic signed [31:0] sum;
		logic signed [7:0]  l;
		logic signed [7:0]  k;
		logic signed [7:0]  h;
	} reflection_t;

	typedef struct packed {
		logic               saturated;
		logic signed [31:0] sum_out;
	} sum_result_t;

	logic                       clk;
	logic                       arst_n    = 1'b0;
	logic                       s_tvalid  = 1'b0;
	logic                       s_tready;
	logic [55:0]                s_tdata   = '0;
	logic                       m_tvalid;
	logic                       m_tready  = 1'b0;
	logic [39:0]                m_tdata;
	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic [sgf_pkg::CIDX_W-1:0] cfg_index = '0;
	logic [sgf_pkg::CFG_W-1:0]  cfg_data  = '0;

	logic signed [15:0] cos_q15 [1024];
	logic [2:0]         setting_shadow;
	logic [15:0]        atom_shadow [3];
	sum_result_t        pending_sums [$];
	int                 mismatches;
	int                 src_idle_pct;
	int                 sink_idle_pct;
	int                 stall_cycles;

	geometric_structure_factor_sg67 dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [63:0] q62_product(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] full;
		full = {64'd0, a} * {64'd0, b};
		return full[125:62];
	endfunction

	// cos((pi/2) * num / 1024) in q1.15, magnitude only
	function automatic logic [15:0] quarter_wave_cos(input int unsigned num);
		logic [63:0] t;
		logic [63:0] t2;
		logic [63:0] term;
		logic [63:0] r;
		longint      acc;
		t = (sgf_pkg::HALF_PI_Q62 / 64'd1024) * 64'(num)
			+ ((sgf_pkg::HALF_PI_Q62 % 64'd1024) * 64'(num)) / 64'd1024;
		t2 = q62_product(t, t);
		term = sgf_pkg::ONE_Q62;
		acc = longint'(sgf_pkg::ONE_Q62);
		for (int n = 1; n <= 16; n++) begin
			term = q62_product(term, t2) / 64'((2 * n - 1) * (2 * n));
			if (n % 2 == 1) begin
				acc -= longint'(term);
			end else begin
				acc += longint'(term);
			end
		end
		if (acc < 0) begin
			acc = 0;
		end
		r = (64'(unsigned'(acc)) + (64'd1 << 46)) >> 47;
		if (r > 64'd32767) begin
			r = 64'd32767;
		end
		return r[15:0];
	endfunction

	task automatic build_cos_q15();
		int unsigned rem;
		for (int i = 0; i < 1024; i++) begin
			rem = (i % 256) * 4;
			case (i / 256)
				0:       cos_q15[i] = quarter_wave_cos(rem);
				1:       cos_q15[i] = -quarter_wave_cos(1024 - rem);
				2:       cos_q15[i] = -quarter_wave_cos(rem);
				default: cos_q15[i] = quarter_wave_cos(1024 - rem);
			endcase
		end
	endtask

	function automatic logic [15:0] index_times_coord(input logic [7:0] idx, input logic [15:0] crd);
		logic [15:0] wide;
		wide = {{8{idx[7]}}, idx};
		return wide * crd;
	endfunction

	function automatic sum_result_t predict_sum(input reflection_t r);
		logic [7:0]  idx [3];
		logic [1:0]  ax_a, ax_b, ax_c, ax_p;
		logic        known;
		logic [15:0] quarter, pa, pb, pc;
		longint      prod, mag, term, total;
		sum_result_t res;
		idx[0] = r.h;
		idx[1] = r.k;
		idx[2] = r.l;
		known = 1'b1;
		ax_a = sgf_pkg::AXIS_X;
		ax_b = sgf_pkg::AXIS_Y;
		ax_c = sgf_pkg::AXIS_Z;
		ax_p = sgf_pkg::AXIS_Y;
		case (setting_shadow)
			sgf_pkg::SET_STANDARD: begin
				ax_a = sgf_pkg::AXIS_X; ax_b = sgf_pkg::AXIS_Y;
				ax_c = sgf_pkg::AXIS_Z; ax_p = sgf_pkg::AXIS_Y;
			end
			sgf_pkg::SET_BA_C: begin
				ax_a = sgf_pkg::AXIS_Y; ax_b = sgf_pkg::AXIS_X;
				ax_c = sgf_pkg::AXIS_Z; ax_p = sgf_pkg::AXIS_X;
			end
			sgf_pkg::SET_CAB: begin
				ax_a = sgf_pkg::AXIS_Y; ax_b = sgf_pkg::AXIS_Z;
				ax_c = sgf_pkg::AXIS_X; ax_p = sgf_pkg::AXIS_Z;
			end
			sgf_pkg::SET_MCBA: begin
				ax_a = sgf_pkg::AXIS_Z; ax_b = sgf_pkg::AXIS_X;
				ax_c = sgf_pkg::AXIS_Y; ax_p = sgf_pkg::AXIS_Y;
			end
			sgf_pkg::SET_BCA: begin
				ax_a = sgf_pkg::AXIS_Z; ax_b = sgf_pkg::AXIS_X;
				ax_c = sgf_pkg::AXIS_Y; ax_p = sgf_pkg::AXIS_X;
			end
			sgf_pkg::SET_A_CB: begin
				ax_a = sgf_pkg::AXIS_X; ax_b = sgf_pkg::AXIS_Z;
				ax_c = sgf_pkg::AXIS_Y; ax_p = sgf_pkg::AXIS_Z;
			end
			default: known = 1'b0;
		endcase
		term = 0;
		if (known) begin
			// a quarter turn per unit of the a index
			quarter = {idx[ax_a][1:0], 14'd0};
			pa = index_times_coord(idx[ax_a], atom_shadow[ax_a]);
			pb = index_times_coord(idx[ax_b], atom_shadow[ax_b]) + quarter;
			pc = index_times_coord(idx[ax_c], atom_shadow[ax_c]) - quarter;
			if (idx[ax_a][0] == idx[ax_p][0]) begin
				prod = longint'(cos_q15[pa[15:6]]) * longint'(cos_q15[pb[15:6]])
					* longint'(cos_q15[pc[15:6]]);
				mag = (prod < 0) ? -prod : prod;
				mag = (mag + (longint'(1) << 24)) >>> 25;
				term = (prod < 0) ? -mag : mag;
			end
		end
		total = longint'(r.sum) + term;
		res.saturated = 1'b0;
		if (total > 64'sd2147483647) begin
			total = 64'sd2147483647;
			res.saturated = 1'b1;
		end else if (total < -64'sd2147483648) begin
			total = -64'sd2147483648;
			res.saturated = 1'b1;
		end
		res.sum_out = total[31:0];
		return res;
	endfunction

	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
	end

	always @(posedge clk) begin
		sum_result_t want, got;
		if (m_tvalid && m_tready) begin
			got = m_tdata[32:0];
			if (pending_sums.size() == 0) begin
				$error("unexpected item: sum_out %0d saturated %0b", got.sum_out, got.saturated);
				mismatches++;
			end else begin
				want = pending_sums.pop_front();
				if (got.sum_out !== want.sum_out) begin
					$error("sum_out: expected %0d, actual %0d", want.sum_out, got.sum_out);
					mismatches++;
				end
				if (got.saturated !== want.saturated) begin
					$error("saturated: expected %0b, actual %0b", want.saturated, got.saturated);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles + 1 >= STALL_LIMIT) begin
			$display("geometric_structure_factor_sg67 regression: fail");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	task automatic write_reg(input logic [sgf_pkg::CIDX_W-1:0] idx,
		input logic [sgf_pkg::CFG_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			sgf_pkg::REG_SETTING: setting_shadow = value[2:0];
			sgf_pkg::REG_ATOM_X:  atom_shadow[0] = value;
			sgf_pkg::REG_ATOM_Y:  atom_shadow[1] = value;
			default:              atom_shadow[2] = value;
		endcase
	endtask

	// upper data bits of the setting write must be ignored
	task automatic configure(input logic [2:0] setting, input logic [15:0] x,
		input logic [15:0] y, input logic [15:0] z);
		logic [12:0] junk;
		junk = $urandom;
		write_reg(sgf_pkg::REG_SETTING, {junk, setting});
		write_reg(sgf_pkg::REG_ATOM_X, x);
		write_reg(sgf_pkg::REG_ATOM_Y, y);
		write_reg(sgf_pkg::REG_ATOM_Z, z);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_reflection(input logic signed [7:0] h, input logic signed [7:0] k,
		input logic signed [7:0] l, input logic signed [31:0] sum);
		reflection_t r;
		r = '{sum: sum, l: l, k: k, h: h};
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= r;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pending_sums.push_back(predict_sum(r));
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_sums.size() != 0) @(posedge clk);
		repeat (PIPE_PAUSE) @(posedge clk);
	endtask

	function automatic logic [15:0] random_coord();
		case ($urandom_range(0, 7))
			0:       return 16'h0000;
			1:       return 16'hFFFF;
			2:       return 16'(($urandom_range(0, 3)) << 14);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic signed [7:0] random_index();
		if ($urandom_range(0, 3) == 0) begin
			return 8'($signed($urandom_range(0, 8)) - 4);
		end
		return 8'($urandom);
	endfunction

	function automatic logic signed [31:0] random_sum();
		case ($urandom_range(0, 7))
			0:       return 32'sh7FFFFFFF - 32'($urandom_range(0, 2000000));
			1:       return 32'sh80000000 + 32'($urandom_range(0, 2000000));
			2:       return 32'($signed($urandom_range(0, 4000000)) - 2000000);
			default: return 32'($urandom);
		endcase
	endfunction

	task automatic test_reset_state();
		send_reflection(8'sd0, 8'sd0, 8'sd0, 32'sd0);
		send_reflection(8'sd1, -8'sd3, 8'sd5, 32'sh7FFFFFFF);
		drain();
	endtask

	task automatic test_directed();
		configure(sgf_pkg::SET_STANDARD, 16'hFFFF, 16'h8000, 16'h0001);
		send_reflection(8'sd127, -8'sd128, 8'sd0, 32'sh7FFFFFFF);
		send_reflection(-8'sd128, 8'sd127, -8'sd1, 32'sh80000000);
		send_reflection(8'sd0, 8'sd0, 8'sd0, 32'sh7FFFFFFF);
		send_reflection(-8'sd1, 8'sd1, 8'sd127, 32'sd0);
		send_reflection(8'sd1, -8'sd1, -8'sd128, -32'sd1);
		drain();
		// all three cosines at -1 pull the sum below the negative limit
		configure(sgf_pkg::SET_STANDARD, 16'h4000, 16'h8000, 16'h0000);
		send_reflection(8'sd2, 8'sd2, 8'sd0, 32'sh80000000);
		send_reflection(8'sd2, 8'sd2, 8'sd0, 32'sh80000064);
		drain();
		for (int s = 0; s < 8; s++) begin
			configure(3'(s), 16'h1357, 16'hC0DE, 16'h7F01);
			send_reflection(8'sd3, -8'sd5, 8'sd8, 32'sh7FFFFF00);
			drain();
		end
	endtask

	task automatic test_random_traffic(input int src_pct, input int sink_pct, input int n_items);
		int          sent;
		int          chunk;
		logic [2:0]  setting;
		src_idle_pct  = src_pct;
		sink_idle_pct = sink_pct;
		sent = 0;
		while (sent < n_items) begin
			setting = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7))
				: 3'($urandom_range(0, 5));
			configure(setting, random_coord(), random_coord(), random_coord());
			chunk = $urandom_range(20, 60);
			if (chunk > n_items - sent) begin
				chunk = n_items - sent;
			end
			for (int i = 0; i < chunk; i++) begin
				send_reflection(random_index(), random_index(), random_index(), random_sum());
			end
			sent += chunk;
			drain();
		end
	endtask

	initial begin
		mismatches     = 0;
		stall_cycles   = 0;
		src_idle_pct   = 0;
		sink_idle_pct  = 0;
		setting_shadow = 3'd0;
		atom_shadow    = '{16'd0, 16'd0, 16'd0};
		build_cos_q15();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_directed();
		test_random_traffic(24, 51, 370);
		test_random_traffic(51, 24, 370);
		test_random_traffic(0, 0, 370);
		mismatches += pending_sums.size();
		if (mismatches == 0) begin
			$display("geometric_structure_factor_sg67 regression: pass");
		end else begin
			$display("geometric_structure_factor_sg67 regression: fail");
		end
		$finish;
	end

endmodule
